// ===== design/smp_pkg.sv =====
package smp_pkg;

    localparam int TIME_WIDTH_DEF = 20;
    localparam int NUM_AXES       = 4;
    localparam int MIN_DURATION   = 100;
    localparam int MS_PER_SEC     = 1000;
    localparam int DEG_SPAN       = 180;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        OP_MOVE = 2'd0,
        OP_TICK = 2'd1,
        OP_STOP = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_SPEED     = 3'd0,
        REG_GAINS     = 3'd1,
        REG_OFFSETS   = 3'd2,
        REG_LIMIT_LO  = 3'd3,
        REG_LIMIT_HI  = 3'd4,
        REG_PULSE_LO  = 3'd5,
        REG_PULSE_HI  = 3'd6,
        REG_UNUSED    = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        K_MOVE,
        K_TICK,
        K_STOP,
        K_NOP
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUR_MUL,
        S_DUR_GO,
        S_DUR_WAIT,
        S_T_WAIT,
        S_K1,
        S_K2,
        S_K3,
        S_INT_MUL,
        S_INT_ADD,
        S_CAL_MUL,
        S_CAL_DEG,
        S_CAL_SPAN,
        S_CAL_GO,
        S_CAL_WAIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        kind_t             kind;
        logic [3:0][15:0]  ang;
    } item_t;

    typedef struct packed {
        logic [9:0]  speed;
        logic [63:0] gains;
        logic [63:0] offsets;
        logic [63:0] limit_lo;
        logic [63:0] limit_hi;
        logic [47:0] pulse_lo;
        logic [47:0] pulse_hi;
    } cfg_t;

    typedef struct packed {
        logic [3:0][11:0] pulse;
        logic             pulses_valid;
        logic             moving;
    } res_t;

    function automatic logic signed [15:0] lane16(input logic [63:0] r, input logic [1:0] i);
        lane16 = signed'(r[i*16 +: 16]);
    endfunction

    function automatic logic [11:0] lane12(input logic [47:0] r, input logic [1:0] i);
        lane12 = r[i*12 +: 12];
    endfunction

endpackage

// ===== design/smp_queue.sv =====
module smp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [15:0]        base_angle,
    input  logic [15:0]        shoulder_angle,
    input  logic [15:0]        elbow_angle,
    input  logic [15:0]        gripper_angle,
    output logic               q_valid,
    output smp_pkg::item_t     q_item,
    input  logic               q_pop
);
    import smp_pkg::*;

    item_t      mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    item_t      new_item;
    logic       push;
    logic       pop;

    always_comb
    begin
        unique case (op_t'(op))
            OP_MOVE: new_item.kind = K_MOVE;
            OP_TICK: new_item.kind = K_TICK;
            OP_STOP: new_item.kind = K_STOP;
            default: new_item.kind = K_NOP;
        endcase
        new_item.ang = {gripper_angle, elbow_angle, shoulder_angle, base_angle};
    end

    assign in_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== design/smp_div.sv =====
module smp_div #(
    parameter int NW = 36,
    parameter int DW = 21
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};
    assign done    = done_reg;
    assign quo     = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CW'(NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== design/smp_engine.sv =====
module smp_engine #(
    parameter int TW = smp_pkg::TIME_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  smp_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  smp_pkg::item_t q_item,
    output logic           q_pop,
    output logic           res_valid,
    input  logic           res_ready,
    output smp_pkg::res_t  res
);
    import smp_pkg::*;

    localparam int NW = TW + 16;
    localparam int DW = TW + 1;

    // ceil(2^29 / 180): exact floor division for magnitudes below 2^21
    localparam logic [21:0] RECIP_180 = 22'd2982617;

    state_t               state_reg, state_next;
    logic signed [15:0]   start_reg [NUM_AXES];
    logic signed [15:0]   start_next [NUM_AXES];
    logic signed [15:0]   cur_reg [NUM_AXES];
    logic signed [15:0]   cur_next [NUM_AXES];
    logic signed [15:0]   tgt_reg [NUM_AXES];
    logic signed [15:0]   tgt_next [NUM_AXES];
    logic                 active_reg, active_next;
    logic [TW-1:0]        elapsed_reg, elapsed_next;
    logic [TW-1:0]        duration_reg, duration_next;
    logic [1:0]           ax_reg, ax_next;
    logic [15:0]          t_reg, t_next;
    logic [16:0]          k_reg, k_next;
    logic signed [8:0]    deg_reg, deg_next;
    logic                 neg_reg, neg_next;
    logic [12:0]          q180_reg, q180_next;
    logic [3:0][11:0]     pulse_reg, pulse_next;
    logic                 pv_reg, pv_next;
    logic                 res_valid_reg;
    res_t                 res_reg;
    logic                 load_res;

    logic signed [18:0]   mul_a, mul_b;
    logic signed [37:0]   mul_reg;

    logic                 div_start;
    logic [NW-1:0]        div_num;
    logic [DW-1:0]        div_den;
    logic                 div_done;
    logic [NW-1:0]        div_quo;

    logic [TW-1:0]        el_inc;
    logic [15:0]          absd [3];
    logic [15:0]          maxd;
    logic [9:0]           spd_eff;
    logic [TW-1:0]        dur_q;
    logic signed [16:0]   dax;
    logic signed [37:0]   p_adj;
    logic signed [37:0]   p_sh;
    logic signed [19:0]   theta;
    logic signed [15:0]   lo_lim, hi_lim, th_cl, th_adj;
    logic signed [12:0]   span;
    logic [37:0]          prod_mag;
    logic [42:0]          recip_prod;
    logic signed [14:0]   qv;
    logic signed [14:0]   pulse_s;

    smp_div #(.NW(NW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        mul_reg <= 38'(mul_a * mul_b);
    end

    // shared datapath values, some decoded from the current axis
    always_comb
    begin
        el_inc  = (elapsed_reg == {TW{1'b1}}) ? elapsed_reg : elapsed_reg + 1'b1;
        spd_eff = (cfg.speed == 10'd0) ? 10'd1 : cfg.speed;
        maxd    = '0;
        for (int i = 0; i < 3; i++)
        begin
            dax     = 17'(tgt_reg[i]) - 17'(start_reg[i]);
            absd[i] = dax[16] ? 16'(-dax) : dax[15:0];
            if (absd[i] > maxd)
            begin
                maxd = absd[i];
            end
        end
        if (|div_quo[NW-1:TW])
        begin
            dur_q = {TW{1'b1}};
        end
        else if (div_quo[TW-1:0] < TW'(MIN_DURATION))
        begin
            dur_q = TW'(MIN_DURATION);
        end
        else
        begin
            dur_q = div_quo[TW-1:0];
        end
        dax    = 17'(tgt_reg[ax_reg]) - 17'(start_reg[ax_reg]);
        // truncate toward zero on the shift by 16
        p_adj  = mul_reg[37] ? mul_reg + 38'sd65535 : mul_reg;
        p_sh   = p_adj >>> 16;
        theta  = 20'(mul_reg >>> 12) + 20'(lane16(cfg.offsets, ax_reg));
        lo_lim = lane16(cfg.limit_lo, ax_reg);
        hi_lim = lane16(cfg.limit_hi, ax_reg);
        if (theta < 20'(lo_lim))
        begin
            th_cl = lo_lim;
        end
        else if (theta > 20'(hi_lim))
        begin
            th_cl = hi_lim;
        end
        else
        begin
            th_cl = theta[15:0];
        end
        th_adj     = th_cl[15] ? th_cl + 16'sd127 : th_cl;
        span       = signed'({1'b0, lane12(cfg.pulse_hi, ax_reg)})
                     - signed'({1'b0, lane12(cfg.pulse_lo, ax_reg)});
        prod_mag   = mul_reg[37] ? 38'(-mul_reg) : 38'(mul_reg);
        recip_prod = 43'(prod_mag[20:0]) * 43'(RECIP_180);
        qv         = neg_reg ? -signed'({2'b0, q180_reg}) : signed'({2'b0, q180_reg});
        pulse_s    = qv + signed'({3'b0, lane12(cfg.pulse_lo, ax_reg)});
    end

    always_comb
    begin
        state_next    = state_reg;
        start_next    = start_reg;
        cur_next      = cur_reg;
        tgt_next      = tgt_reg;
        active_next   = active_reg;
        elapsed_next  = elapsed_reg;
        duration_next = duration_reg;
        ax_next       = ax_reg;
        t_next        = t_reg;
        k_next        = k_reg;
        deg_next      = deg_reg;
        neg_next      = neg_reg;
        q180_next     = q180_reg;
        pulse_next    = pulse_reg;
        pv_next       = pv_reg;
        q_pop         = 1'b0;
        load_res      = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        div_start     = 1'b0;
        div_num       = '0;
        div_den       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    pv_next    = 1'b0;
                    pulse_next = '0;
                    state_next = S_EMIT;
                    unique case (q_item.kind)
                        K_MOVE:
                        begin
                            for (int i = 0; i < NUM_AXES; i++)
                            begin
                                start_next[i] = cur_reg[i];
                                tgt_next[i]   = signed'(q_item.ang[i]);
                            end
                            state_next = S_DUR_MUL;
                        end
                        K_TICK:
                        begin
                            if (active_reg)
                            begin
                                elapsed_next = el_inc;
                                ax_next      = 2'd0;
                                pv_next      = 1'b1;
                                if (el_inc >= duration_reg)
                                begin
                                    cur_next    = tgt_reg;
                                    active_next = 1'b0;
                                    state_next  = S_CAL_MUL;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    div_num    = {el_inc, 16'd0};
                                    div_den    = {1'b0, duration_reg};
                                    state_next = S_T_WAIT;
                                end
                            end
                        end
                        K_STOP:
                        begin
                            active_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DUR_MUL:
            begin
                mul_a      = 19'(maxd);
                mul_b      = 19'(MS_PER_SEC);
                state_next = S_DUR_GO;
            end
            S_DUR_GO:
            begin
                div_start  = 1'b1;
                div_num    = NW'(mul_reg[25:0]);
                div_den    = DW'({spd_eff, 7'd0});
                state_next = S_DUR_WAIT;
            end
            S_DUR_WAIT:
            begin
                if (div_done)
                begin
                    duration_next = dur_q;
                    elapsed_next  = '0;
                    active_next   = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_T_WAIT:
            begin
                if (div_done)
                begin
                    t_next     = div_quo[15:0];
                    state_next = S_K1;
                end
            end
            S_K1:
            begin
                mul_a      = 19'(t_reg);
                mul_b      = 19'(t_reg);
                state_next = S_K2;
            end
            S_K2:
            begin
                mul_a      = 19'(mul_reg[31:16]);
                mul_b      = 19'(18'd196608 - {1'b0, t_reg, 1'b0});
                state_next = S_K3;
            end
            S_K3:
            begin
                k_next     = mul_reg[32:16];
                ax_next    = 2'd0;
                state_next = S_INT_MUL;
            end
            S_INT_MUL:
            begin
                mul_a      = 19'(dax);
                mul_b      = 19'(k_reg);
                state_next = S_INT_ADD;
            end
            S_INT_ADD:
            begin
                cur_next[ax_reg] = start_reg[ax_reg] + p_sh[15:0];
                ax_next          = ax_reg + 1'b1;
                state_next       = (ax_reg == 2'd3) ? S_CAL_MUL : S_INT_MUL;
            end
            S_CAL_MUL:
            begin
                mul_a      = 19'(cur_reg[ax_reg]);
                mul_b      = 19'(lane16(cfg.gains, ax_reg));
                state_next = S_CAL_DEG;
            end
            S_CAL_DEG:
            begin
                deg_next   = 9'(th_adj >>> 7);
                state_next = S_CAL_SPAN;
            end
            S_CAL_SPAN:
            begin
                mul_a      = 19'(deg_reg);
                mul_b      = 19'(span);
                state_next = S_CAL_GO;
            end
            S_CAL_GO:
            begin
                // divide the magnitude by 180 through the reciprocal, keep the sign
                neg_next   = mul_reg[37];
                q180_next  = recip_prod[41:29];
                state_next = S_CAL_WAIT;
            end
            S_CAL_WAIT:
            begin
                if (pulse_s < 0)
                begin
                    pulse_next[ax_reg] = 12'd0;
                end
                else if (pulse_s > 15'sd4095)
                begin
                    pulse_next[ax_reg] = 12'd4095;
                end
                else
                begin
                    pulse_next[ax_reg] = pulse_s[11:0];
                end
                ax_next    = ax_reg + 1'b1;
                state_next = (ax_reg == 2'd3) ? S_EMIT : S_CAL_MUL;
            end
            S_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    load_res   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                start_reg[i] <= '0;
                cur_reg[i]   <= '0;
                tgt_reg[i]   <= '0;
            end
            active_reg    <= 1'b0;
            elapsed_reg   <= '0;
            duration_reg  <= '0;
            ax_reg        <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg    <= start_next;
            cur_reg      <= cur_next;
            tgt_reg      <= tgt_next;
            active_reg   <= active_next;
            elapsed_reg  <= elapsed_next;
            duration_reg <= duration_next;
            ax_reg       <= ax_next;
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        k_reg     <= k_next;
        deg_reg   <= deg_next;
        neg_reg   <= neg_next;
        q180_reg  <= q180_next;
        pulse_reg <= pulse_next;
        pv_reg    <= pv_next;
        if (load_res)
        begin
            res_reg.pulse        <= pulse_reg;
            res_reg.pulses_valid <= pv_reg;
            res_reg.moving       <= active_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/servo_smoothstep_motion_profiler.sv =====
// channel   | handshake             | payload
// ----------+-----------------------+---------------------------------------------
// input     | in_valid / in_ready   | op, base/shoulder/elbow/gripper_angle
// output    | out_valid / out_ready | pulse_base..pulse_gripper, pulses_valid, moving
// config    | APB psel/penable      | paddr, pwdata, prdata (64-bit, 8-byte stride)
//
// A two-entry queue takes transactions while the sequencer works. Once popped, a stop,
// idle tick or unused op goes straight to the result; a move computes its duration on
// the shared multiplier and the bit-serial divider; an active tick divides for t, forms
// the smoothstep weight, then interpolates and calibrates each axis, or only calibrates
// when it ends the move. The result register loads in the emit state. Reset clears control
// and config state (speed to 90), not the datapath. A stalled output holds the sequencer.
module servo_smoothstep_motion_profiler #(
    parameter int TIME_WIDTH = smp_pkg::TIME_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic signed [15:0] base_angle,
    input  logic signed [15:0] shoulder_angle,
    input  logic signed [15:0] elbow_angle,
    input  logic signed [15:0] gripper_angle,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] pulse_base,
    output logic [11:0] pulse_shoulder,
    output logic [11:0] pulse_elbow,
    output logic [11:0] pulse_gripper,
    output logic        pulses_valid,
    output logic        moving,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import smp_pkg::*;

    cfg_t     cfg_reg;
    logic     cfg_wr;
    reg_idx_t idx;
    logic     q_valid;
    item_t    q_item;
    logic     q_pop;
    res_t     res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed    <= 10'd90;
            cfg_reg.gains    <= '0;
            cfg_reg.offsets  <= '0;
            cfg_reg.limit_lo <= '0;
            cfg_reg.limit_hi <= '0;
            cfg_reg.pulse_lo <= '0;
            cfg_reg.pulse_hi <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (idx)
                REG_SPEED:    cfg_reg.speed    <= pwdata[9:0];
                REG_GAINS:    cfg_reg.gains    <= pwdata;
                REG_OFFSETS:  cfg_reg.offsets  <= pwdata;
                REG_LIMIT_LO: cfg_reg.limit_lo <= pwdata;
                REG_LIMIT_HI: cfg_reg.limit_hi <= pwdata;
                REG_PULSE_LO: cfg_reg.pulse_lo <= pwdata[47:0];
                REG_PULSE_HI: cfg_reg.pulse_hi <= pwdata[47:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SPEED:    prdata = 64'(cfg_reg.speed);
            REG_GAINS:    prdata = cfg_reg.gains;
            REG_OFFSETS:  prdata = cfg_reg.offsets;
            REG_LIMIT_LO: prdata = cfg_reg.limit_lo;
            REG_LIMIT_HI: prdata = cfg_reg.limit_hi;
            REG_PULSE_LO: prdata = 64'(cfg_reg.pulse_lo);
            REG_PULSE_HI: prdata = 64'(cfg_reg.pulse_hi);
            default:      prdata = '0;
        endcase
    end

    smp_queue u_queue (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .base_angle     (base_angle),
        .shoulder_angle (shoulder_angle),
        .elbow_angle    (elbow_angle),
        .gripper_angle  (gripper_angle),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    smp_engine #(.TW(TIME_WIDTH)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    assign pulse_base     = res.pulse[0];
    assign pulse_shoulder = res.pulse[1];
    assign pulse_elbow    = res.pulse[2];
    assign pulse_gripper  = res.pulse[3];
    assign pulses_valid   = res.pulses_valid;
    assign moving         = res.moving;

endmodule

// ===== bench/smp_checker.sv =====
`timescale 1ns / 100ps

module smp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  op,
    input  logic [15:0] base_angle,
    input  logic [15:0] shoulder_angle,
    input  logic [15:0] elbow_angle,
    input  logic [15:0] gripper_angle,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [11:0] pulse_base,
    input  logic [11:0] pulse_shoulder,
    input  logic [11:0] pulse_elbow,
    input  logic [11:0] pulse_gripper,
    input  logic        pulses_valid,
    input  logic        moving,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending,
    output int          moves_done
);
    import smp_pkg::*;

    localparam longint unsigned ELAPSED_MAX = (64'd1 << TIME_WIDTH_DEF) - 1;

    logic [9:0]  speed_r;
    logic [63:0] gains_r, offsets_r, lim_lo_r, lim_hi_r;
    logic [47:0] pls_lo_r, pls_hi_r;

    logic signed [15:0] start_ang [4];
    logic signed [15:0] cur_ang [4];
    logic signed [15:0] tgt_ang [4];
    bit                 in_motion;
    longint unsigned    elapsed, dur;

    res_t pulse_q[$];

    function automatic logic signed [15:0] lane_s16(input logic [63:0] r, input int i);
        return signed'(r[i*16 +: 16]);
    endfunction

    function automatic logic [11:0] axis_pulse(input int i);
        longint theta, lo, hi, deg, ulo, uhi, p;
        theta = ((longint'(lane_s16(gains_r, i)) * longint'(cur_ang[i])) >>> 12)
                + longint'(lane_s16(offsets_r, i));
        lo = lane_s16(lim_lo_r, i);
        hi = lane_s16(lim_hi_r, i);
        if (theta < lo)
            theta = lo;
        else if (theta > hi)
            theta = hi;
        deg = theta / 128;
        ulo = longint'(pls_lo_r[i*12 +: 12]);
        uhi = longint'(pls_hi_r[i*12 +: 12]);
        p = deg * (uhi - ulo) / 180 + ulo;
        if (p < 0)
            p = 0;
        if (p > 4095)
            p = 4095;
        return p[11:0];
    endfunction

    function automatic res_t advance_profile(input logic [1:0] kind, input logic [63:0] angs);
        res_t r;
        longint unsigned maxd, spd, d_abs, t, t2, k;
        longint delta;
        r = '0;
        if (kind == OP_MOVE) begin
            maxd = 0;
            spd = (speed_r == 0) ? 1 : speed_r;
            for (int i = 0; i < 4; i++) begin
                start_ang[i] = cur_ang[i];
                tgt_ang[i] = angs[i*16 +: 16];
                if (i < 3) begin
                    delta = longint'(tgt_ang[i]) - longint'(start_ang[i]);
                    d_abs = (delta < 0) ? -delta : delta;
                    if (d_abs > maxd)
                        maxd = d_abs;
                end
            end
            dur = (maxd * 1000) / (spd * 128);
            if (dur > ELAPSED_MAX)
                dur = ELAPSED_MAX;
            if (dur < MIN_DURATION)
                dur = MIN_DURATION;
            elapsed = 0;
            in_motion = 1;
        end else if (kind == OP_TICK) begin
            if (in_motion) begin
                if (elapsed < ELAPSED_MAX)
                    elapsed++;
                if (elapsed >= dur) begin
                    // snap to the target and end the move
                    for (int i = 0; i < 4; i++)
                        cur_ang[i] = tgt_ang[i];
                    in_motion = 0;
                    moves_done++;
                end else begin
                    t = (elapsed << 16) / dur;
                    t2 = (t * t) >> 16;
                    k = (t2 * ((64'd3 << 16) - 2 * t)) >> 16;
                    for (int i = 0; i < 4; i++) begin
                        delta = longint'(tgt_ang[i]) - longint'(start_ang[i]);
                        cur_ang[i] = 16'(longint'(start_ang[i])
                                         + (delta * longint'(k)) / 65536);
                    end
                end
                for (int i = 0; i < 4; i++)
                    r.pulse[i] = axis_pulse(i);
                r.pulses_valid = 1'b1;
            end
        end else if (kind == OP_STOP) begin
            in_motion = 0;
        end
        r.moving = in_motion;
        return r;
    endfunction

    assign pending = pulse_q.size();

    always @(posedge clk or negedge rst_n) begin
        res_t   want;
        res_t   got;
        logic [2:0] idx;
        if (!rst_n) begin
            speed_r   = 10'd90;
            gains_r   = '0;
            offsets_r = '0;
            lim_lo_r  = '0;
            lim_hi_r  = '0;
            pls_lo_r  = '0;
            pls_hi_r  = '0;
            for (int i = 0; i < 4; i++) begin
                start_ang[i] = '0;
                cur_ang[i] = '0;
                tgt_ang[i] = '0;
            end
            in_motion = 0;
            elapsed = 0;
            dur = 0;
            mismatches = 0;
            moves_done = 0;
            pulse_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                idx = paddr[5:3];
                case (reg_idx_t'(idx))
                    REG_SPEED:    speed_r   = pwdata[9:0];
                    REG_GAINS:    gains_r   = pwdata;
                    REG_OFFSETS:  offsets_r = pwdata;
                    REG_LIMIT_LO: lim_lo_r  = pwdata;
                    REG_LIMIT_HI: lim_hi_r  = pwdata;
                    REG_PULSE_LO: pls_lo_r  = pwdata[47:0];
                    REG_PULSE_HI: pls_hi_r  = pwdata[47:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                pulse_q.push_back(advance_profile(op, {gripper_angle, elbow_angle,
                                                       shoulder_angle, base_angle}));
            if (out_valid && out_ready) begin
                got.pulse[0] = pulse_base;
                got.pulse[1] = pulse_shoulder;
                got.pulse[2] = pulse_elbow;
                got.pulse[3] = pulse_gripper;
                got.pulses_valid = pulses_valid;
                got.moving = moving;
                if (pulse_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transaction %h", got);
                end else begin
                    want = pulse_q.pop_front();
                    if (want !== got) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: pulses exp %0d %0d %0d %0d v%0d m%0d, got %0d %0d %0d %0d v%0d m%0d",
                                want.pulse[0], want.pulse[1], want.pulse[2], want.pulse[3],
                                want.pulses_valid, want.moving,
                                got.pulse[0], got.pulse[1], got.pulse[2], got.pulse[3],
                                got.pulses_valid, got.moving);
                    end
                end
            end
        end
    end

endmodule

// ===== bench/servo_smoothstep_motion_profiler_tb.sv =====
`timescale 1ns / 100ps

module servo_smoothstep_motion_profiler_tb;
    import smp_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 170;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic signed [15:0] base_angle, shoulder_angle, elbow_angle, gripper_angle;
    logic        out_valid;
    logic        out_ready;
    logic [11:0] pulse_base, pulse_shoulder, pulse_elbow, pulse_gripper;
    logic        pulses_valid;
    logic        moving;
    logic        psel, penable, pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    int mismatches, pending, moves_done;
    int sent;
    int snd_idle, rcv_idle;
    int quiet_cycles;

    servo_smoothstep_motion_profiler dut (.*);

    smp_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op),
        .base_angle(base_angle), .shoulder_angle(shoulder_angle),
        .elbow_angle(elbow_angle), .gripper_angle(gripper_angle),
        .out_valid(out_valid), .out_ready(out_ready),
        .pulse_base(pulse_base), .pulse_shoulder(pulse_shoulder),
        .pulse_elbow(pulse_elbow), .pulse_gripper(pulse_gripper),
        .pulses_valid(pulses_valid), .moving(moving),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatches(mismatches), .pending(pending), .moves_done(moves_done)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rcv_idle);

    // end the run when nothing moves for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    task automatic send_item(input op_t kind, input logic [15:0] a0, input logic [15:0] a1,
                             input logic [15:0] a2, input logic [15:0] a3);
        if (sent < 240) begin
            snd_idle = 20;
            rcv_idle = 62;
        end else if (sent < 480) begin
            snd_idle = 62;
            rcv_idle = 20;
        end else begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        if ($urandom_range(99) < snd_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < snd_idle)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        base_angle <= a0;
        shoulder_angle <= a1;
        elbow_angle <= a2;
        gripper_angle <= a3;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [63:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_setting(input int phase);
        case (phase)
            1: begin
                apb_write(REG_SPEED, 64'd1023);
                apb_write(REG_GAINS, {4{16'h1000}});
                apb_write(REG_OFFSETS, {4{16'h0000}});
                apb_write(REG_LIMIT_LO, {4{16'h0000}});
                apb_write(REG_LIMIT_HI, {4{16'd23040}});
                apb_write(REG_PULSE_LO, 64'({4{12'd500}}));
                apb_write(REG_PULSE_HI, 64'({4{12'd2500}}));
                apb_write(REG_UNUSED, {$urandom, $urandom});
            end
            2: begin
                apb_write(REG_SPEED, 64'($urandom_range(1, 1023)));
                apb_write(REG_GAINS, {$urandom, $urandom});
                apb_write(REG_OFFSETS, {$urandom, $urandom});
                apb_write(REG_LIMIT_LO, {$urandom, $urandom});
                apb_write(REG_LIMIT_HI, {$urandom, $urandom});
                apb_write(REG_PULSE_LO, {$urandom, $urandom});
                apb_write(REG_PULSE_HI, {$urandom, $urandom});
            end
            default: begin
                // zero speed, extreme gains, partly inverted limits, full, reversed and empty pulse spans
                apb_write(REG_SPEED, 64'd0);
                apb_write(REG_GAINS, {16'h7fff, 16'h8000, 16'hffff, 16'h7fff});
                apb_write(REG_OFFSETS, {16'h8000, 16'h7fff, 16'h0000, 16'hffff});
                apb_write(REG_LIMIT_LO, {16'h7fff, 16'h8000, 16'h1000, 16'h8000});
                apb_write(REG_LIMIT_HI, {16'h8000, 16'h7fff, 16'h0100, 16'h7fff});
                apb_write(REG_PULSE_LO, 64'({12'hfff, 12'h000, 12'hfff, 12'h000}));
                apb_write(REG_PULSE_HI, 64'({12'h000, 12'hfff, 12'hfff, 12'hfff}));
            end
        endcase
    endtask

    function automatic logic [15:0] near_angle();
        return 16'($signed($urandom_range(0, 2400)) - 1200);
    endfunction

    task automatic random_traffic(input int count);
        int stop_at, n_ticks;
        stop_at = sent + count;
        while (sent < stop_at) begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(3) == 0)
                    send_item(OP_MOVE, rand16(), rand16(), rand16(), rand16());
                else
                    send_item(OP_MOVE, near_angle(), near_angle(), near_angle(), rand16());
                n_ticks = $urandom_range(0, 190);
                if (n_ticks > stop_at - sent)
                    n_ticks = stop_at - sent;
                repeat (n_ticks) send_item(OP_TICK, rand16(), rand16(), rand16(), rand16());
                if (sent < stop_at && $urandom_range(2) == 0)
                    send_item(OP_STOP, rand16(), rand16(), rand16(), rand16());
            end else begin
                send_item(op_t'($urandom_range(3)), rand16(), rand16(), rand16(), rand16());
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_NONE;
        base_angle = '0;
        shoulder_angle = '0;
        elbow_angle = '0;
        gripper_angle = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sent = 0;
        snd_idle = 20;
        rcv_idle = 62;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle tick, unused op, stop, extreme targets
        send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_item(OP_STOP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_MOVE, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        repeat (3) send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_NONE, 16'h1234, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_STOP, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_item(OP_MOVE, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_item(OP_MOVE, 16'h0040, 16'hffc0, 16'h0000, 16'h5555);
        repeat (12) send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        for (int phase = 0; phase < 4; phase++) begin
            if (phase != 0) begin
                drain_and_settle();
                load_setting(phase);
            end
            random_traffic(ITEMS_PER_PHASE);
        end

        drain_and_settle();
        $display("sent %0d input transactions over four register settings", sent);
        $display("%0d moves ran to their target", moves_done);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
